@@ rtl/adc_scan_moving_sum_macros.svh @@
// Assertion macros for the RTL files; only asms_back includes them.
// Each expects clk and rst_n in scope.
`ifndef ADC_SCAN_MOVING_SUM_MACROS_SVH
`define ADC_SCAN_MOVING_SUM_MACROS_SVH

// Same-cycle implication.
`define ASMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/asms_pkg.sv @@
`default_nettype none
package asms_pkg;

  localparam int unsigned CHANNELS  = 8;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned SUM_OUT_W = 15;
  localparam int unsigned WIN_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;

  // Channel 4 is never converted; the scan jumps from 3 straight to 6.
  localparam logic [CH_W-1:0] CH_SKIPPED     = 3'd4;
  localparam logic [CH_W-1:0] CH_SKIP_TARGET = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_CH0,
    REG_WIN_CH1,
    REG_WIN_CH2,
    REG_WIN_CH3,
    REG_WIN_CH6,
    REG_WIN_CH7,
    REG_WRAP_START
  } reg_idx_t;

  // One classified sample on its way from the front end to the update unit.
  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
    logic [WIN_W-1:0]    win;
    logic [CH_W-1:0]     next_ch;
  } item_t;

  // Request to clear one channel's ring state when its window is written.
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
  } clr_t;

  function automatic logic [CH_W-1:0] next_channel(input logic [CH_W-1:0] ch,
                                                   input logic wrap);
    logic [CH_W:0] n;
    n = {1'b0, ch} + (CH_W+1)'(1);
    if (n == {1'b0, CH_SKIPPED}) n = {1'b0, CH_SKIP_TARGET};
    if (n >= (CH_W+1)'(CHANNELS)) n = {{CH_W{1'b0}}, wrap};
    return n[CH_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/adc_scan_moving_sum.sv @@
// An accepted sample word is queued and then popped into the update unit, which reads
// then writes the ring RAM and takes no new word until its result word is registered;
// a 2-entry queue lets the input take words while a result waits.
// Reset: synchronous, active-low rst_n clears channel select, windows, heads,
// sums and ring fill flags at once; the ring RAM is not swept, so no wait after reset.
`default_nettype none
module adc_scan_moving_sum #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [9:0] sample, [15:10] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] channel, [12:3] raw_sample, [27:13] window_sum, [30:28] next_channel,
  // [31] zero
  output logic      [31:0] out_tdata,
  output logic             out_tuser,  // [0] averaging_on
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam int unsigned Q_DEPTH = 2;

  asms_pkg::item_t q_wr_item;
  asms_pkg::item_t q_rd_item;
  asms_pkg::clr_t  clr;
  logic            q_push, q_pop, q_full, q_empty;
  logic [$bits(asms_pkg::item_t)-1:0] q_rd_data;

  asms_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[asms_pkg::SAMPLE_W-1:0]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item),
    .clr       (clr)
  );

  asms_fifo #(
    .WIDTH ($bits(asms_pkg::item_t)),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign q_rd_item = asms_pkg::item_t'(q_rd_data);

  asms_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .clr        (clr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

@@ rtl/asms_ram.sv @@
`default_nettype none
module asms_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/asms_fifo.sv @@
`default_nettype none
module asms_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= wr_data;
        wr_ptr_r        <= bump(wr_ptr_r);
      end
      if (do_pop) rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/asms_front.sv @@
`default_nettype none
module asms_front #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [asms_pkg::SAMPLE_W-1:0]      in_sample,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [asms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [asms_pkg::WIN_W-1:0]         cfg_data,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output asms_pkg::item_t                         q_item,
  output asms_pkg::clr_t                          clr
);

  localparam int unsigned CMP_W = asms_pkg::WIN_W + 1;

  logic [asms_pkg::CH_W-1:0]  cur_r;
  logic [asms_pkg::WIN_W-1:0] win_r [asms_pkg::CHANNELS];
  logic                       wrap_r;
  logic [asms_pkg::WIN_W-1:0] win_clamped;
  logic                       win_wr;
  logic [asms_pkg::CH_W-1:0]  win_ch;
  logic                       wrap_wr;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign cfg_ready = 1'b1;

  always_comb begin
    q_item.ch      = cur_r;
    q_item.sample  = in_sample;
    q_item.win     = win_r[cur_r];
    q_item.next_ch = asms_pkg::next_channel(cur_r, wrap_r);
  end

  // Windows above the ring length saturate.
  assign win_clamped = ({1'b0, cfg_data} > CMP_W'(MAX_WINDOW)) ?
                       asms_pkg::WIN_W'(MAX_WINDOW) : cfg_data;

  always_comb begin
    win_wr  = 1'b0;
    win_ch  = '0;
    wrap_wr = 1'b0;
    if (cfg_valid) begin
      unique case (asms_pkg::reg_idx_t'(cfg_index))
        asms_pkg::REG_WIN_CH0: begin win_wr = 1'b1; win_ch = 3'd0; end
        asms_pkg::REG_WIN_CH1: begin win_wr = 1'b1; win_ch = 3'd1; end
        asms_pkg::REG_WIN_CH2: begin win_wr = 1'b1; win_ch = 3'd2; end
        asms_pkg::REG_WIN_CH3: begin win_wr = 1'b1; win_ch = 3'd3; end
        asms_pkg::REG_WIN_CH6: begin win_wr = 1'b1; win_ch = 3'd6; end
        asms_pkg::REG_WIN_CH7: begin win_wr = 1'b1; win_ch = 3'd7; end
        asms_pkg::REG_WRAP_START: wrap_wr = 1'b1;
        default: ;
      endcase
    end
  end

  assign clr.valid = win_wr;
  assign clr.ch    = win_ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      wrap_r <= 1'b0;
      for (int i = 0; i < asms_pkg::CHANNELS; i++) win_r[i] <= '0;
    end else begin
      if (q_push) cur_r <= q_item.next_ch;
      if (win_wr) win_r[win_ch] <= win_clamped;
      if (wrap_wr) wrap_r <= cfg_data[0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/asms_back.sv @@
`default_nettype none
`include "adc_scan_moving_sum_macros.svh"
module asms_back #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  asms_pkg::item_t      q_item,
  output logic                 q_pop,
  input  asms_pkg::clr_t       clr,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [31:0]          out_tdata,
  output logic                 out_tuser
);

  localparam int unsigned HW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned ADDR_W = asms_pkg::CH_W + HW;
  localparam int unsigned DEPTH  = asms_pkg::CHANNELS * (1 << HW);
  localparam int unsigned SUM_W  =
    $clog2(MAX_WINDOW * ((1 << asms_pkg::SAMPLE_W) - 1) + 1);
  localparam int unsigned CMP_W  = asms_pkg::WIN_W + 1;

  typedef enum logic {ST_IDLE, ST_UPD} state_t;

  state_t                        st_r;
  asms_pkg::item_t               item_r;
  logic [HW-1:0]                 hnew_r;
  logic [HW-1:0]                 head_r [asms_pkg::CHANNELS];
  logic [SUM_W-1:0]              sum_r  [asms_pkg::CHANNELS];
  logic [asms_pkg::CHANNELS-1:0] full_r;

  logic                              out_tvalid_r;
  logic [asms_pkg::CH_W-1:0]         out_ch_r;
  logic [asms_pkg::SAMPLE_W-1:0]     out_sample_r;
  logic [asms_pkg::SUM_OUT_W-1:0]    out_sum_r;
  logic                              out_tuser_r;
  logic [asms_pkg::CH_W-1:0]         out_next_r;

  logic [CMP_W-1:0]                  hstep;
  logic [HW-1:0]                     hnew;
  logic                              done;
  logic                              avg;
  logic [asms_pkg::SAMPLE_W-1:0]     rd_data;
  logic [asms_pkg::SAMPLE_W-1:0]     old;
  logic [SUM_W-1:0]                  sum_new;
  logic [SUM_W+asms_pkg::SUM_OUT_W-1:0] sum_ext;
  logic [asms_pkg::SUM_OUT_W-1:0]    sum_field;

  // Head for the popped word, worked out while the ring entry is read.
  assign hstep = CMP_W'(head_r[q_item.ch]) + CMP_W'(1);
  assign hnew  = (hstep >= CMP_W'(q_item.win) || hstep >= CMP_W'(MAX_WINDOW)) ?
                 '0 : hstep[HW-1:0];
  assign q_pop = (st_r == ST_IDLE) && !q_empty;

  assign done = (st_r == ST_UPD) && (!out_tvalid_r || out_tready);
  assign avg  = (item_r.win != '0);

  // After a clear the ring fills in order and reaches entry 0 last, so the
  // entry being replaced holds data only once that channel has wrapped.
  assign old       = full_r[item_r.ch] ? rd_data : '0;
  assign sum_new   = sum_r[item_r.ch] - SUM_W'(old) + SUM_W'(item_r.sample);
  assign sum_ext   = {{asms_pkg::SUM_OUT_W{1'b0}}, sum_new};
  assign sum_field = avg ? sum_ext[asms_pkg::SUM_OUT_W-1:0] : '0;

  asms_ram #(
    .WIDTH (asms_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (done && avg),
    .wr_addr ({item_r.ch, hnew_r}),
    .wr_data (item_r.sample),
    .rd_en   (q_pop),
    .rd_addr ({q_item.ch, hnew}),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      full_r       <= '0;
      for (int i = 0; i < asms_pkg::CHANNELS; i++) begin
        head_r[i] <= '0;
        sum_r[i]  <= '0;
      end
    end else begin
      if (out_tvalid_r && out_tready && !done) out_tvalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            item_r <= q_item;
            hnew_r <= hnew;
            st_r   <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (done) begin
            out_tvalid_r <= 1'b1;
            out_ch_r     <= item_r.ch;
            out_sample_r <= item_r.sample;
            out_sum_r    <= sum_field;
            out_tuser_r  <= avg;
            out_next_r   <= item_r.next_ch;
            if (avg) begin
              head_r[item_r.ch] <= hnew_r;
              sum_r[item_r.ch]  <= sum_new;
              if (hnew_r == '0) full_r[item_r.ch] <= 1'b1;
            end
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
      if (clr.valid) begin
        head_r[clr.ch] <= '0;
        sum_r[clr.ch]  <= '0;
        full_r[clr.ch] <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = {1'b0, out_next_r, out_sum_r, out_sample_r, out_ch_r};

  `ASMS_ASSERT_NEXT(a_pop_starts_update, q_pop, st_r == ST_UPD, "pop did not start update")
  `ASMS_ASSERT_NOW(a_plain_sum_zero, out_tvalid_r && !out_tuser_r, out_sum_r == '0, "sum without window")
  `ASMS_ASSERT_NOW(a_head_in_window, done && avg, CMP_W'(hnew_r) < CMP_W'(item_r.win), "head beyond window")

endmodule
`default_nettype wire
